// File: src/rra_pkg.sv
package rra_pkg;

  // Default coordinate width of the canvas
  localparam int COORD_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_BOX_LEFT      = 3'd0;
  localparam cfg_index_t REG_BOX_TOP       = 3'd1;
  localparam cfg_index_t REG_BOX_WIDTH     = 3'd2;
  localparam cfg_index_t REG_BOX_HEIGHT    = 3'd3;
  localparam cfg_index_t REG_CORNER_RADIUS = 3'd4;
  localparam cfg_index_t REG_FILL_RGBA     = 3'd5;

  localparam logic [CFG_DATA_BITS-1:0] FILL_RGBA_RESET = 32'hFFFF_FFFF;

  // Color channels in order red, green, blue (index 2 down to 0)
  typedef logic [2:0][7:0] rgb_t;

endpackage

// File: src/rounded_rect_alpha_fill.sv
// Rounded rectangle fill with alpha blend, one pixel per transaction.
// Five register stages, the first loaded at the accepting edge.
// Throughput: one pixel per clock while out_stall is low; each stage holds one
// pixel, so the sustained rate is set by the stage handshake alone.
// Reset (rst, synchronous): clears all stage valid bits, loads box registers
// with 0 and fill_rgba with all ones.
module rounded_rect_alpha_fill #(
  parameter int COORD_BITS = rra_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write,
  input  rra_pkg::cfg_index_t              cfg_index,
  input  logic [rra_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // pixel input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [COORD_BITS-1:0]            pixel_x,
  input  logic [COORD_BITS-1:0]            pixel_y,
  input  logic [7:0]                       dst_red,
  input  logic [7:0]                       dst_green,
  input  logic [7:0]                       dst_blue,
  input  logic [7:0]                       dst_alpha,
  // pixel output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [7:0]                       out_alpha,
  output logic                             covered
);

  import rra_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int RB = COORD_BITS - 1;      // radius and corner offset width
  localparam int SB = 2 * (COORD_BITS - 1); // squared offset width

  // Configuration registers
  logic [C:0]    box_left;
  logic [C:0]    box_top;
  logic [C-1:0]  box_width;
  logic [C-1:0]  box_height;
  logic [RB-1:0] corner_radius;
  logic [31:0]   fill_rgba;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      box_left      <= '0;
      box_top       <= '0;
      box_width     <= '0;
      box_height    <= '0;
      corner_radius <= '0;
      fill_rgba     <= FILL_RGBA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOX_LEFT:      box_left      <= cfg_data[C:0];
        REG_BOX_TOP:       box_top       <= cfg_data[C:0];
        REG_BOX_WIDTH:     box_width     <= cfg_data[C-1:0];
        REG_BOX_HEIGHT:    box_height    <= cfg_data[C-1:0];
        REG_CORNER_RADIUS: corner_radius <= cfg_data[RB-1:0];
        REG_FILL_RGBA:     fill_rgba     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Effective radius: min(radius, width/2, height/2)
  logic [RB-1:0] half_w;
  logic [RB-1:0] half_h;
  logic [RB-1:0] r_min_wh;
  logic [RB-1:0] radius;
  logic [C-1:0]  w_minus_r;
  logic [C-1:0]  h_minus_r;
  rgb_t          fill_rgb;
  logic [7:0]    fill_a;
  logic [7:0]    fill_inv_a;

  assign half_w     = box_width[C-1:1];
  assign half_h     = box_height[C-1:1];
  assign r_min_wh   = (half_w < half_h) ? half_w : half_h;
  assign radius     = (corner_radius < r_min_wh) ? corner_radius : r_min_wh;
  assign w_minus_r  = box_width - {1'b0, radius};
  assign h_minus_r  = box_height - {1'b0, radius};
  assign fill_rgb   = fill_rgba[31:8];
  assign fill_a     = fill_rgba[7:0];
  // Weight of the old pixel: 255 - fill alpha
  assign fill_inv_a = 8'hFF - fill_a;

  // Stage handshake: a stage takes new data when empty or draining
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // Stage 1: box-relative coordinates and box test
  logic [C+1:0] dx_full;
  logic [C+1:0] dy_full;
  logic         in_box_next;

  assign dx_full = {2'b00, pixel_x} - {box_left[C], box_left};
  assign dy_full = {2'b00, pixel_y} - {box_top[C], box_top};
  assign in_box_next = !dx_full[C+1] && !dy_full[C+1]
                    && (dx_full[C:0] < {1'b0, box_width})
                    && (dy_full[C:0] < {1'b0, box_height});

  logic [C-1:0] s1_dx;
  logic [C-1:0] s1_dy;
  logic         s1_in_box;
  rgb_t         s1_rgb;
  logic [7:0]   s1_alpha;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_dx     <= dx_full[C-1:0];
      s1_dy     <= dy_full[C-1:0];
      s1_in_box <= in_box_next;
      s1_rgb    <= {dst_red, dst_green, dst_blue};
      s1_alpha  <= dst_alpha;
    end
  end

  // Stage 2: corner classification and offsets from the corner center
  logic         at_left, at_right, at_top, at_bottom;
  logic [C-1:0] cx_left, cx_right, cy_top, cy_bottom;

  assign at_left   = s1_dx < {1'b0, radius};
  assign at_right  = s1_dx >= w_minus_r;
  assign at_top    = s1_dy < {1'b0, radius};
  assign at_bottom = s1_dy >= h_minus_r;
  assign cx_left   = {1'b0, radius} - s1_dx;
  assign cx_right  = s1_dx - w_minus_r + {{(C-1){1'b0}}, 1'b1};
  assign cy_top    = {1'b0, radius} - s1_dy;
  assign cy_bottom = s1_dy - h_minus_r + {{(C-1){1'b0}}, 1'b1};

  logic [RB-1:0] s2_cx;
  logic [RB-1:0] s2_cy;
  logic          s2_corner;
  logic          s2_in_box;
  rgb_t          s2_rgb;
  logic [7:0]    s2_alpha;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_cx     <= at_left ? cx_left[RB-1:0] : cx_right[RB-1:0];
      s2_cy     <= at_top ? cy_top[RB-1:0] : cy_bottom[RB-1:0];
      s2_corner <= (at_left || at_right) && (at_top || at_bottom);
      s2_in_box <= s1_in_box;
      s2_rgb    <= s1_rgb;
      s2_alpha  <= s1_alpha;
    end
  end

  // Stage 3: squares for the circle test and blend products
  logic [SB-1:0]     s3_sq_x;
  logic [SB-1:0]     s3_sq_y;
  logic [SB-1:0]     s3_rr;
  logic              s3_corner;
  logic              s3_in_box;
  logic [2:0][15:0]  s3_prod_fill;
  logic [2:0][15:0]  s3_prod_dst;
  rgb_t              s3_rgb;
  logic [7:0]        s3_alpha;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sq_x   <= {{RB{1'b0}}, s2_cx} * {{RB{1'b0}}, s2_cx};
      s3_sq_y   <= {{RB{1'b0}}, s2_cy} * {{RB{1'b0}}, s2_cy};
      s3_rr     <= {{RB{1'b0}}, radius} * {{RB{1'b0}}, radius};
      s3_corner <= s2_corner;
      s3_in_box <= s2_in_box;
      for (int i = 0; i < 3; i++) begin
        s3_prod_fill[i] <= {8'd0, fill_rgb[i]} * {8'd0, fill_a};
        s3_prod_dst[i]  <= {8'd0, s2_rgb[i]} * {8'd0, fill_inv_a};
      end
      s3_rgb    <= s2_rgb;
      s3_alpha  <= s2_alpha;
    end
  end

  // Stage 4: coverage decision and blend sums
  logic [SB:0] dist_sq;

  assign dist_sq = {1'b0, s3_sq_x} + {1'b0, s3_sq_y};

  logic             s4_covered;
  logic [2:0][15:0] s4_sum;
  rgb_t             s4_rgb;
  logic [7:0]       s4_alpha;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_covered <= s3_in_box && (!s3_corner || (dist_sq <= {1'b0, s3_rr}));
      for (int i = 0; i < 3; i++) begin
        s4_sum[i] <= s3_prod_fill[i] + s3_prod_dst[i];
      end
      s4_rgb   <= s3_rgb;
      s4_alpha <= s3_alpha;
    end
  end

  // Stage 5: divide by 255 and select the blended or original pixel
  logic [2:0][16:0] div_acc;
  rgb_t             blend_rgb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_acc[i]   = {1'b0, s4_sum[i]} + {9'd0, s4_sum[i][15:8]} + 17'd1;
      blend_rgb[i] = div_acc[i][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      covered <= s4_covered;
      if (s4_covered) begin
        out_red   <= blend_rgb[2];
        out_green <= blend_rgb[1];
        out_blue  <= blend_rgb[0];
        out_alpha <= (s4_alpha > fill_a) ? s4_alpha : fill_a;
      end else begin
        out_red   <= s4_rgb[2];
        out_green <= s4_rgb[1];
        out_blue  <= s4_rgb[0];
        out_alpha <= s4_alpha;
      end
    end
  end

  // An accepted transaction always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted pixel did not enter stage 1");

  // A pixel waiting in the last internal stage is not dropped by a stall
  a_stage4_holds: assert property (@(posedge clk) disable iff (rst)
    v4 && !rdy5 |=> v4)
    else $error("stage 4 pixel lost under output stall");

  // A covered pixel never ends with alpha below the fill alpha
  a_covered_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && covered |-> out_alpha >= fill_a)
    else $error("covered pixel alpha below fill alpha");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rra_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int LATENCY = 5;
  localparam int QUIET_LIMIT = 3000;
  localparam int STALL_HOLD = 300;
  localparam int SETS = 10;
  localparam int ITEMS_PER_SET = 85;

  // Register indexes outside the map; writes to them must be dropped
  localparam cfg_index_t REG_SPARE_LO = 3'd6;
  localparam cfg_index_t REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [7:0]    alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       covered;
  } pixel_out_t;

  // Scoreboard: shadow registers, rounded box painter, queue of drawn pixels
  class fill_scoreboard;
    logic signed [CB:0]   box_left;
    logic signed [CB:0]   box_top;
    logic [CB-1:0]        box_width;
    logic [CB-1:0]        box_height;
    logic [CB-2:0]        corner_radius;
    logic [31:0]          fill_rgba;
    pixel_out_t           drawn[$];
    int unsigned          errors;

    function new();
      box_left = '0;
      box_top = '0;
      box_width = '0;
      box_height = '0;
      corner_radius = '0;
      fill_rgba = FILL_RGBA_RESET;
      errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [31:0] data);
      case (idx)
        REG_BOX_LEFT:      box_left = data[CB:0];
        REG_BOX_TOP:       box_top = data[CB:0];
        REG_BOX_WIDTH:     box_width = data[CB-1:0];
        REG_BOX_HEIGHT:    box_height = data[CB-1:0];
        REG_CORNER_RADIUS: corner_radius = data[CB-2:0];
        REG_FILL_RGBA:     fill_rgba = data;
        default: ;
      endcase
    endfunction

    // Clamp the radius to half the width and half the height
    function int used_radius();
      int r;
      r = corner_radius;
      if (r > int'(box_width) / 2) r = int'(box_width) / 2;
      if (r > int'(box_height) / 2) r = int'(box_height) / 2;
      return r;
    endfunction

    function logic [7:0] mix(logic [7:0] c, logic [7:0] p, int a);
      return 8'((int'(c) * a + int'(p) * (255 - a)) / 255);
    endfunction

    function pixel_out_t draw_pixel(pixel_in_t p);
      pixel_out_t o;
      int dx, dy, w, h, r, cx, cy, a;
      bit hit, at_left, at_right, at_top, at_bottom;
      w = box_width;
      h = box_height;
      r = used_radius();
      dx = int'(p.x) - int'(box_left);
      dy = int'(p.y) - int'(box_top);
      hit = dx >= 0 && dy >= 0 && dx < w && dy < h;
      // Inside a corner square, keep only pixels within the arc
      if (hit) begin
        at_left = dx < r;
        at_right = dx >= w - r;
        at_top = dy < r;
        at_bottom = dy >= h - r;
        cx = at_left ? r - dx : dx - (w - r - 1);
        cy = at_top ? r - dy : dy - (h - r - 1);
        if ((at_left || at_right) && (at_top || at_bottom))
          hit = cx * cx + cy * cy <= r * r;
      end
      a = fill_rgba[7:0];
      if (hit) begin
        o.red = mix(fill_rgba[31:24], p.red, a);
        o.green = mix(fill_rgba[23:16], p.green, a);
        o.blue = mix(fill_rgba[15:8], p.blue, a);
        o.alpha = (p.alpha > fill_rgba[7:0]) ? p.alpha : fill_rgba[7:0];
        o.covered = 1'b1;
      end else begin
        o.red = p.red;
        o.green = p.green;
        o.blue = p.blue;
        o.alpha = p.alpha;
        o.covered = 1'b0;
      end
      return o;
    endfunction

    function void accept_pixel(pixel_in_t p);
      drawn.push_back(draw_pixel(p));
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_drawn(pixel_out_t got);
      pixel_out_t want;
      if (drawn.size() == 0) begin
        $error("pixel result with no transaction outstanding");
        errors++;
        return;
      end
      want = drawn.pop_front();
      compare("out_red", want.red, got.red);
      compare("out_green", want.green, got.green);
      compare("out_blue", want.blue, got.blue);
      compare("out_alpha", want.alpha, got.alpha);
      compare("covered", want.covered, got.covered);
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  cfg_index_t               cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CB-1:0]            pixel_x = '0;
  logic [CB-1:0]            pixel_y = '0;
  logic [7:0]               dst_red = '0;
  logic [7:0]               dst_green = '0;
  logic [7:0]               dst_blue = '0;
  logic [7:0]               dst_alpha = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [7:0]               out_red;
  logic [7:0]               out_green;
  logic [7:0]               out_blue;
  logic [7:0]               out_alpha;
  logic                     covered;

  fill_scoreboard board = new();
  pixel_out_t     seen;
  int             send_idle = 30;
  int             recv_idle = 80;
  int             hold_left = 0;
  int             quiet = 0;
  cfg_index_t     wr_idx[$];
  logic [31:0]    wr_val[$];

  rounded_rect_alpha_fill dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .dst_red   (dst_red),
    .dst_green (dst_green),
    .dst_blue  (dst_blue),
    .dst_alpha (dst_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .covered   (covered)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the output at random, or hold it off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Check every pixel transaction leaving the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{out_red, out_green, out_blue, out_alpha, covered};
      board.check_drawn(seen);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offset from the box edge: anywhere across the span, or near either end
  function automatic int pick_offset(int span, int rad);
    case ($urandom_range(2))
      0: return int'($urandom_range(span + 7)) - 4;
      1: return int'($urandom_range(rad + 4)) - 2;
      default: return span + 1 - int'($urandom_range(rad + 4));
    endcase
  endfunction

  function automatic pixel_in_t make_pixel();
    pixel_in_t p;
    int px, py, r;
    r = board.used_radius();
    px = int'(board.box_left) + pick_offset(board.box_width, r);
    py = int'(board.box_top) + pick_offset(board.box_height, r);
    if (px < 0 || px > 4095 || $urandom_range(99) < 15) px = $urandom_range(4095);
    if (py < 0 || py > 4095 || $urandom_range(99) < 15) py = $urandom_range(4095);
    p.x = px[CB-1:0];
    p.y = py[CB-1:0];
    p.red = pick_byte();
    p.green = pick_byte();
    p.blue = pick_byte();
    p.alpha = pick_byte();
    return p;
  endfunction

  // Offer one pixel after a random gap and hold it until accepted
  task automatic send_pixel(pixel_in_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= p.x;
    pixel_y <= p.y;
    dst_red <= p.red;
    dst_green <= p.green;
    dst_blue <= p.blue;
    dst_alpha <= p.alpha;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.accept_pixel(p);
  endtask

  task automatic send_at(int x, int y);
    pixel_in_t p;
    p = make_pixel();
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    send_pixel(p);
  endtask

  // Drop valid, let every outstanding pixel come back, then settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.drawn.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic queue_reg(cfg_index_t idx, logic [31:0] val);
    wr_idx.push_back(idx);
    wr_val.push_back(val);
  endtask

  // Write all queued registers on back-to-back edges
  task automatic flush_regs();
    cfg_index_t  idx;
    logic [31:0] val;
    while (wr_idx.size() > 0) begin
      idx = wr_idx.pop_front();
      val = wr_val.pop_front();
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      board.write_reg(idx, val);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic setup_set(int s);
    case (s)
      0: begin
        queue_reg(REG_BOX_LEFT, 32'(-2048));
        queue_reg(REG_BOX_TOP, 32'(-2048));
        queue_reg(REG_BOX_WIDTH, 4095);
        queue_reg(REG_BOX_HEIGHT, 4095);
        queue_reg(REG_CORNER_RADIUS, 2047);
        queue_reg(REG_FILL_RGBA, $urandom & 32'hFFFF_FF00);
      end
      1: begin
        queue_reg(REG_BOX_LEFT, 4095);
        queue_reg(REG_BOX_TOP, 4095);
        queue_reg(REG_BOX_WIDTH, 1);
        queue_reg(REG_BOX_HEIGHT, 1);
        queue_reg(REG_CORNER_RADIUS, 2047);
        queue_reg(REG_FILL_RGBA, $urandom | 32'h0000_00FF);
      end
      2: begin
        queue_reg(REG_BOX_LEFT, 32'(-4096));
        queue_reg(REG_BOX_TOP, 32'(-4096));
        queue_reg(REG_BOX_WIDTH, 0);
        queue_reg(REG_BOX_HEIGHT, 4095);
        queue_reg(REG_CORNER_RADIUS, 5);
        queue_reg(REG_FILL_RGBA, $urandom);
      end
      3: begin
        // square corners: plain rectangle
        queue_reg(REG_BOX_LEFT, 50);
        queue_reg(REG_BOX_TOP, 60);
        queue_reg(REG_BOX_WIDTH, 37);
        queue_reg(REG_BOX_HEIGHT, 25);
        queue_reg(REG_CORNER_RADIUS, 0);
        queue_reg(REG_FILL_RGBA, $urandom);
      end
      4: begin
        queue_reg(REG_BOX_LEFT, 100);
        queue_reg(REG_BOX_TOP, 50);
        queue_reg(REG_BOX_WIDTH, 60);
        queue_reg(REG_BOX_HEIGHT, 0);
        queue_reg(REG_CORNER_RADIUS, 10);
        queue_reg(REG_FILL_RGBA, 32'hFFFF_FFFF);
      end
      default: begin
        queue_reg(REG_BOX_LEFT, ($urandom_range(4) == 0) ? $urandom
                                  : 32'(int'($urandom_range(300)) - 60));
        queue_reg(REG_BOX_TOP, ($urandom_range(4) == 0) ? $urandom
                                 : 32'(int'($urandom_range(300)) - 60));
        queue_reg(REG_BOX_WIDTH, ($urandom_range(5) == 0) ? $urandom_range(4095)
                                   : $urandom_range(80));
        queue_reg(REG_BOX_HEIGHT, ($urandom_range(5) == 0) ? $urandom_range(4095)
                                    : $urandom_range(80));
        queue_reg(REG_CORNER_RADIUS, ($urandom_range(5) == 0) ? $urandom_range(2047)
                                       : $urandom_range(45));
        queue_reg(REG_FILL_RGBA, $urandom);
      end
    endcase
  endtask

  initial begin
    int s, i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: empty box, nothing covered
    send_at(0, 0);
    send_at(4095, 4095);
    wait_idle();

    // Box at (10,20), 40x30, radius 8; spare indexes must not disturb it
    queue_reg(REG_BOX_LEFT, 10);
    queue_reg(REG_BOX_TOP, 20);
    queue_reg(REG_BOX_WIDTH, 40);
    queue_reg(REG_BOX_HEIGHT, 30);
    queue_reg(REG_CORNER_RADIUS, 8);
    queue_reg(REG_FILL_RGBA, 32'h8040_C07F);
    queue_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    queue_reg(REG_SPARE_HI, 32'h0000_0000);
    flush_regs();

    // Each corner: outer tip and inside the arc; top-left also just outside the arc
    send_at(10, 20);
    send_at(12, 22);
    send_at(13, 23);
    send_at(49, 20);
    send_at(46, 23);
    send_at(10, 49);
    send_at(13, 46);
    send_at(49, 49);
    send_at(46, 46);
    // Interior, a top edge point beside a corner, and all four outsides
    send_at(30, 35);
    send_at(18, 20);
    send_at(9, 35);
    send_at(50, 35);
    send_at(30, 19);
    send_at(30, 50);
    send_at(4095, 4095);

    // Random traffic over several box settings and idle patterns
    for (s = 0; s < SETS; s++) begin
      wait_idle();
      if (s < 4) begin
        send_idle = 30;
        recv_idle = 80;
      end else if (s < 7) begin
        send_idle = 80;
        recv_idle = 30;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      setup_set(s);
      flush_regs();
      for (i = 0; i < ITEMS_PER_SET; i++) begin
        // back up the pipeline while pixels keep coming
        if (s == SETS - 1 && i == 30) hold_left = STALL_HOLD;
        send_pixel(make_pixel());
      end
    end
    wait_idle();

    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
